### design/dop_pkg.sv
// Shared constants, types and codes for the DHCP offer option parser.
`default_nettype none

package dop_pkg;

    localparam int MAX_MESSAGE_BYTES = 1024;
    // Byte offset counter saturates at MAX_MESSAGE_BYTES, so it must hold that value.
    localparam int OFS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    // Next code index reaches at most 255 + 2 + 255.
    localparam int NEXT_W = 10;
    localparam int CMP_W = (OFS_W > NEXT_W) ? OFS_W : NEXT_W;

    localparam int OPTIONS_BASE = 236;
    localparam int FIRST_CODE_INDEX = 4;
    localparam int LAST_CODE_INDEX = 255;
    localparam int CLIENT_FIRST = 16;
    localparam int CLIENT_LAST = 19;
    localparam logic [7:0] OP_BOOTREPLY = 8'd2;

    localparam int SLOTS = 4;
    localparam int SLOT_SERVER = 0;
    localparam int SLOT_MASK = 1;
    localparam int SLOT_DNS = 2;
    localparam int SLOT_LEASE = 3;

    localparam logic [7:0] CODE_SERVER_ID = 8'd54;
    localparam logic [7:0] CODE_SUBNET_MASK = 8'd1;
    localparam logic [7:0] CODE_DNS = 8'd6;
    localparam logic [7:0] CODE_LEASE = 8'd51;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_REPLY = 3'd1;
    localparam logic [2:0] ST_NO_SERVER = 3'd2;
    localparam logic [2:0] ST_NO_MASK = 3'd3;
    localparam logic [2:0] ST_NO_DNS = 3'd4;
    localparam logic [2:0] ST_NO_LEASE = 3'd5;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LENGTH,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [31:0] client;
        logic [31:0] server;
        logic [31:0] mask;
        logic [31:0] dns;
        logic [31:0] lease;
    } sess_t;

    typedef struct packed {
        logic step;
        logic last;
    } step_ctl_t;

    function automatic logic [7:0] slot_code(input logic [1:0] slot);
        logic [7:0] code;
        case (slot)
            2'd0: code = CODE_SERVER_ID;
            2'd1: code = CODE_SUBNET_MASK;
            2'd2: code = CODE_DNS;
            2'd3: code = CODE_LEASE;
            default: code = CODE_SERVER_ID;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### design/dop_if.sv
// Channel interfaces: message byte stream in, parse result out.
`default_nettype none

interface dop_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface dop_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] client_ip;
    logic [31:0] server_ip;
    logic [31:0] subnet_mask;
    logic [31:0] dns_address;
    logic [31:0] lease_seconds;

    modport source (
        output valid, output status, output client_ip, output server_ip,
        output subnet_mask, output dns_address, output lease_seconds, input ready
    );
    modport sink (
        input valid, input status, input client_ip, input server_ip,
        input subnet_mask, input dns_address, input lease_seconds, output ready
    );
endinterface

`default_nettype wire

### design/dop_parser.sv
// Per-byte message state update, option walk and session commit.
`default_nettype none

module dop_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dop_pkg::step_ctl_t ctl,
    input  wire logic [7:0]       rx_byte,
    output logic [2:0]            status,
    output dop_pkg::sess_t        sess
);

    logic [dop_pkg::OFS_W-1:0]  offset_reg;
    logic                       reply_reg;
    logic [31:0]                cap_reg;
    logic [dop_pkg::NEXT_W-1:0] next_reg;
    dop_pkg::phase_t            phase_reg;
    logic [dop_pkg::SLOTS-1:0]  flags_reg;
    logic [31:0]                val_reg [dop_pkg::SLOTS];
    logic [7:0]                 pos_reg [dop_pkg::SLOTS];
    dop_pkg::sess_t             sess_reg;

    logic                       reply_next;
    logic [31:0]                cap_next;
    logic [dop_pkg::NEXT_W-1:0] next_next;
    dop_pkg::phase_t            phase_next;
    logic [dop_pkg::SLOTS-1:0]  flags_next;
    logic [31:0]                val_next [dop_pkg::SLOTS];
    logic [7:0]                 pos_next [dop_pkg::SLOTS];
    dop_pkg::sess_t             sess_next;

    logic                       take;
    logic                       in_opts;
    logic [dop_pkg::CMP_W-1:0]  idx;
    logic [dop_pkg::CMP_W-1:0]  next_c;
    logic [dop_pkg::CMP_W-1:0]  rel [dop_pkg::SLOTS];
    logic [dop_pkg::NEXT_W-1:0] next_sum;

    assign take = offset_reg < dop_pkg::OFS_W'(dop_pkg::MAX_MESSAGE_BYTES);
    assign in_opts = offset_reg >= dop_pkg::OFS_W'(dop_pkg::OPTIONS_BASE);
    assign idx = dop_pkg::CMP_W'(offset_reg) - dop_pkg::CMP_W'(dop_pkg::OPTIONS_BASE);
    assign next_c = dop_pkg::CMP_W'(next_reg);
    assign next_sum = next_reg + dop_pkg::NEXT_W'(rx_byte) + dop_pkg::NEXT_W'(2);

    always_comb
    begin
        reply_next = reply_reg;
        cap_next   = cap_reg;
        next_next  = next_reg;
        phase_next = phase_reg;
        flags_next = flags_reg;
        for (int s = 0; s < dop_pkg::SLOTS; s++)
        begin
            val_next[s] = val_reg[s];
            pos_next[s] = pos_reg[s];
            rel[s] = idx - dop_pkg::CMP_W'(pos_reg[s]);
        end

        if (take)
        begin
            if (offset_reg == '0)
                reply_next = (rx_byte == dop_pkg::OP_BOOTREPLY);
            if (offset_reg >= dop_pkg::OFS_W'(dop_pkg::CLIENT_FIRST) &&
                offset_reg <= dop_pkg::OFS_W'(dop_pkg::CLIENT_LAST))
                cap_next = cap_reg | ({rx_byte, 24'd0} >> {offset_reg[1:0], 3'b000});

            if (in_opts)
            begin
                // value bytes of options already matched; uses flags before this byte
                for (int s = 0; s < dop_pkg::SLOTS; s++)
                begin
                    if (flags_reg[s] && idx >= dop_pkg::CMP_W'(pos_reg[s]) &&
                        rel[s] >= dop_pkg::CMP_W'(2) && rel[s] <= dop_pkg::CMP_W'(5))
                        val_next[s] = val_reg[s] |
                            ({rx_byte, 24'd0} >> {rel[s][1:0] + 2'd2, 3'b000});
                end

                if (phase_reg == dop_pkg::PH_CODE && idx == next_c)
                begin
                    for (int s = 0; s < dop_pkg::SLOTS; s++)
                    begin
                        if (!flags_reg[s] && rx_byte == dop_pkg::slot_code(2'(s)))
                        begin
                            flags_next[s] = 1'b1;
                            pos_next[s] = idx[7:0];
                        end
                    end
                    phase_next = dop_pkg::PH_LENGTH;
                end
                else if (phase_reg == dop_pkg::PH_LENGTH &&
                         idx == next_c + dop_pkg::CMP_W'(1))
                begin
                    next_next = next_sum;
                    phase_next = (next_sum > dop_pkg::NEXT_W'(dop_pkg::LAST_CODE_INDEX)) ?
                                 dop_pkg::PH_DONE : dop_pkg::PH_CODE;
                end
            end
        end
    end

    // commit in order, stopping at the first option not seen
    always_comb
    begin
        sess_next = sess_reg;
        status = dop_pkg::ST_OK;
        if (!reply_next)
            status = dop_pkg::ST_NOT_REPLY;
        else
        begin
            sess_next.client = cap_next;
            if (!flags_next[dop_pkg::SLOT_SERVER])
                status = dop_pkg::ST_NO_SERVER;
            else
            begin
                sess_next.server = val_next[dop_pkg::SLOT_SERVER];
                if (!flags_next[dop_pkg::SLOT_MASK])
                    status = dop_pkg::ST_NO_MASK;
                else
                begin
                    sess_next.mask = val_next[dop_pkg::SLOT_MASK];
                    if (!flags_next[dop_pkg::SLOT_DNS])
                        status = dop_pkg::ST_NO_DNS;
                    else
                    begin
                        sess_next.dns = val_next[dop_pkg::SLOT_DNS];
                        if (!flags_next[dop_pkg::SLOT_LEASE])
                            status = dop_pkg::ST_NO_LEASE;
                        else
                            sess_next.lease = val_next[dop_pkg::SLOT_LEASE];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            reply_reg  <= 1'b0;
            cap_reg    <= '0;
            next_reg   <= dop_pkg::NEXT_W'(dop_pkg::FIRST_CODE_INDEX);
            phase_reg  <= dop_pkg::PH_CODE;
            flags_reg  <= '0;
            for (int s = 0; s < dop_pkg::SLOTS; s++)
            begin
                val_reg[s] <= '0;
                pos_reg[s] <= '0;
            end
            sess_reg   <= '0;
        end
        else if (ctl.step)
        begin
            if (ctl.last)
            begin
                offset_reg <= '0;
                reply_reg  <= 1'b0;
                cap_reg    <= '0;
                next_reg   <= dop_pkg::NEXT_W'(dop_pkg::FIRST_CODE_INDEX);
                phase_reg  <= dop_pkg::PH_CODE;
                flags_reg  <= '0;
                for (int s = 0; s < dop_pkg::SLOTS; s++)
                begin
                    val_reg[s] <= '0;
                    pos_reg[s] <= '0;
                end
                sess_reg   <= sess_next;
            end
            else
            begin
                offset_reg <= offset_reg + dop_pkg::OFS_W'(take);
                reply_reg  <= reply_next;
                cap_reg    <= cap_next;
                next_reg   <= next_next;
                phase_reg  <= phase_next;
                flags_reg  <= flags_next;
                for (int s = 0; s < dop_pkg::SLOTS; s++)
                begin
                    val_reg[s] <= val_next[s];
                    pos_reg[s] <= pos_next[s];
                end
            end
        end
    end

    assign sess = sess_reg;

endmodule

`default_nettype wire

### design/dhcp_offer_option_parser.sv
// DHCP offer option parser: top level with input and result registers.
//
// rx carries one message byte per transfer, op byte first; last_byte marks
// the final byte. res carries one transfer per message: status and the five
// session values as they stand after the commit.
// Each byte goes into an input register and is parsed from there; a
// message result is loaded into the result register when its last byte is parsed.
// Throughput is one byte per cycle, set by the single input register,
// except while a final byte is held. While a result waits on res, non-final
// bytes of the next message keep flowing; a final byte is held in the input
// register until the result register is free, and rx.ready drops behind it.
// Reset clears the message state, the session values (to zero) and both
// valid flags. Bytes past the maximum message length only count for their
// last_byte mark; options past index 255 are never seen.
`default_nettype none

module dhcp_offer_option_parser (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dop_byte_if.sink      rx,
    dop_result_if.source  res
);

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 out_valid_reg;
    logic [2:0]           status_reg;
    logic                 process;
    logic [2:0]           status;
    dop_pkg::sess_t       sess;
    dop_pkg::step_ctl_t   ctl;

    assign process = in_valid_reg && (!last_reg || !out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || process;

    assign ctl.step = process;
    assign ctl.last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
            last_reg <= rx.last_byte;
        end
    end

    dop_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rx_byte (byte_reg),
        .status  (status),
        .sess    (sess)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (process && last_reg)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (process && last_reg)
            status_reg <= status;
    end

    // session registers only move on a commit, which also loads the result
    assign res.valid          = out_valid_reg;
    assign res.status         = status_reg;
    assign res.client_ip      = sess.client;
    assign res.server_ip      = sess.server;
    assign res.subnet_mask    = sess.mask;
    assign res.dns_address    = sess.dns;
    assign res.lease_seconds  = sess.lease;

endmodule

`default_nettype wire

### verif/tb_dhcp_offer_option_parser.sv
// Self-checking testbench for the DHCP offer option parser: directed offers, then random ones.
`timescale 1ns / 1ps

module tb_dhcp_offer_option_parser;

    import dop_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int RESET_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BYTES = 1650;
    localparam int DRAIN_EVERY = 8;

    localparam logic [7:0] CODE_PAD = 8'd0;
    localparam logic [7:0] CODE_END = 8'd255;
    localparam logic [7:0] CODE_FILLER = 8'd12;
    localparam logic [SLOTS-1:0][7:0] WATCHED =
        {CODE_LEASE, CODE_DNS, CODE_SUBNET_MASK, CODE_SERVER_ID};

    typedef enum logic [3:0] {
        SHAPE_OP_ONLY,
        SHAPE_HEADER_ONLY,
        SHAPE_FULL,
        SHAPE_NO_SERVER,
        SHAPE_NO_MASK,
        SHAPE_NO_DNS,
        SHAPE_NO_LEASE,
        SHAPE_TRUNCATED,
        SHAPE_PAST_255,
        SHAPE_AT_255,
        SHAPE_PAD_END,
        SHAPE_OVERLAP,
        SHAPE_DUPLICATE,
        SHAPE_OVERLONG
    } shape_t;

    typedef struct packed {
        shape_t     shape;
        logic [7:0] op;
        logic [7:0] fill;
        logic       typed;
        logic [2:0] status;
    } row_t;

    typedef struct packed {
        logic [2:0] status;
        sess_t      sess;
    } offer_result_t;

    localparam int NUM_ROWS = 18;

    // status is typed in only where it is obvious; other rows lean on the predictor
    row_t offer_plan [NUM_ROWS] = '{
        '{SHAPE_OP_ONLY,     8'h00, 8'h00, 1'b1, ST_NOT_REPLY},
        '{SHAPE_OP_ONLY,     8'h02, 8'h00, 1'b1, ST_NO_SERVER},
        '{SHAPE_HEADER_ONLY, 8'h02, 8'hFF, 1'b1, ST_NO_SERVER},
        '{SHAPE_FULL,        8'h02, 8'hFF, 1'b1, ST_OK},
        '{SHAPE_FULL,        8'h02, 8'h00, 1'b1, ST_OK},
        '{SHAPE_FULL,        8'h01, 8'hA5, 1'b1, ST_NOT_REPLY},
        '{SHAPE_FULL,        8'hFF, 8'h5A, 1'b1, ST_NOT_REPLY},
        '{SHAPE_NO_SERVER,   8'h02, 8'h11, 1'b1, ST_NO_SERVER},
        '{SHAPE_NO_MASK,     8'h02, 8'h22, 1'b1, ST_NO_MASK},
        '{SHAPE_NO_DNS,      8'h02, 8'h33, 1'b1, ST_NO_DNS},
        '{SHAPE_NO_LEASE,    8'h02, 8'h44, 1'b1, ST_NO_LEASE},
        '{SHAPE_TRUNCATED,   8'h02, 8'hC3, 1'b0, ST_OK},
        '{SHAPE_PAST_255,    8'h02, 8'h77, 1'b1, ST_NO_SERVER},
        '{SHAPE_AT_255,      8'h02, 8'h88, 1'b1, ST_NO_MASK},
        '{SHAPE_PAD_END,     8'h02, 8'h99, 1'b0, ST_OK},
        '{SHAPE_OVERLAP,     8'h02, 8'hE7, 1'b0, ST_OK},
        '{SHAPE_DUPLICATE,   8'h02, 8'h3C, 1'b0, ST_OK},
        '{SHAPE_OVERLONG,    8'h02, 8'h96, 1'b0, ST_OK}
    };

    logic clk = 1'b0;
    logic rst_n;

    dop_byte_if   rx ();
    dop_result_if res ();

    dhcp_offer_option_parser i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor state
    int unsigned   ofs_count;
    logic          op_is_reply;
    logic [31:0]   client_capture;
    int unsigned   code_index;
    phase_t        walk;
    logic [3:0]    found;
    logic [31:0]   opt_value [SLOTS];
    int unsigned   opt_index [SLOTS];
    sess_t         session;

    offer_result_t offer_expect_q [$];
    logic [7:0]    msg_q [$];

    int   error_count = 0;
    int   bytes_sent;
    int   stall_cycles = 0;
    int   ready_hold = 0;
    logic quiet = 1'b0;

    function automatic void clear_offer();
        ofs_count = 0;
        op_is_reply = 1'b0;
        client_capture = '0;
        code_index = FIRST_CODE_INDEX;
        walk = PH_CODE;
        found = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            opt_value[s] = '0;
            opt_index[s] = 0;
        end
    endfunction

    function automatic void parse_offer_byte(input logic [7:0] b, input logic last,
                                             output logic done, output offer_result_t r);
        int unsigned i;
        logic [2:0]  st;
        done = 1'b0;
        r = '0;
        if (ofs_count < MAX_MESSAGE_BYTES)
        begin
            if (ofs_count == 0)
                op_is_reply = (b == OP_BOOTREPLY);
            if (ofs_count >= CLIENT_FIRST && ofs_count <= CLIENT_LAST)
                client_capture = client_capture | (32'(b) << (8 * (CLIENT_LAST - ofs_count)));
            if (ofs_count >= OPTIONS_BASE)
            begin
                i = ofs_count - OPTIONS_BASE;
                // a byte may be a value byte and a code at once
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (found[s] && i >= opt_index[s] + 2 && i <= opt_index[s] + 5)
                        opt_value[s] = opt_value[s] | (32'(b) << (8 * (5 - (i - opt_index[s]))));
                end
                if (walk == PH_CODE && i == code_index)
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (!found[s] && b == WATCHED[s])
                        begin
                            found[s] = 1'b1;
                            opt_index[s] = i;
                        end
                    end
                    walk = PH_LENGTH;
                end
                else if (walk == PH_LENGTH && i == code_index + 1)
                begin
                    code_index = code_index + 2 + b;
                    walk = (code_index > LAST_CODE_INDEX) ? PH_DONE : PH_CODE;
                end
            end
            ofs_count++;
        end
        if (last)
        begin
            done = 1'b1;
            st = ST_OK;
            if (!op_is_reply)
                st = ST_NOT_REPLY;
            else
            begin
                session.client = client_capture;
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (st == ST_OK)
                    begin
                        // missing-option codes run in slot order
                        if (!found[s])
                            st = 3'(ST_NO_SERVER + s);
                        else
                        begin
                            case (s)
                                SLOT_SERVER: session.server = opt_value[s];
                                SLOT_MASK:   session.mask = opt_value[s];
                                SLOT_DNS:    session.dns = opt_value[s];
                                default:     session.lease = opt_value[s];
                            endcase
                        end
                    end
                end
            end
            r.status = st;
            r.sess = session;
            clear_offer();
        end
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void start_offer(input logic [7:0] op, input logic [31:0] client);
        msg_q.delete();
        for (int k = 0; k < OPTIONS_BASE; k++)
            msg_q.push_back(8'($urandom));
        msg_q[0] = op;
        for (int k = 0; k < 4; k++)
            msg_q[CLIENT_FIRST + k] = client[31 - 8 * k -: 8];
        // magic cookie
        msg_q.push_back(8'd99);
        msg_q.push_back(8'd130);
        msg_q.push_back(8'd83);
        msg_q.push_back(8'd99);
    endfunction

    function automatic void add_option(input logic [7:0] code, input logic [7:0] len,
                                       input logic [31:0] value);
        msg_q.push_back(code);
        msg_q.push_back(len);
        for (int k = 0; k < len; k++)
            msg_q.push_back(k < 4 ? value[31 - 8 * k -: 8] : 8'($urandom));
    endfunction

    function automatic void add_watched(input logic [3:0] skip, input logic [31:0] value);
        for (int s = 0; s < SLOTS; s++)
        begin
            add_option(CODE_FILLER, 8'd3, $urandom);
            if (!skip[s])
                add_option(WATCHED[s], 8'd4, value);
        end
        add_option(CODE_END, 8'd0, 32'd0);
    endfunction

    function automatic void build_shape(input shape_t shape, input logic [7:0] op,
                                        input logic [7:0] fill);
        logic [31:0] value;
        value = {4{fill}};
        start_offer(op, value);
        case (shape)
            SHAPE_OP_ONLY:
            begin
                msg_q.delete();
                msg_q.push_back(op);
            end
            SHAPE_HEADER_ONLY:
            begin
                while (msg_q.size() > CLIENT_LAST + 1)
                    void'(msg_q.pop_back());
            end
            SHAPE_FULL:      add_watched(4'b0000, value);
            SHAPE_NO_SERVER: add_watched(4'b0001, value);
            SHAPE_NO_MASK:   add_watched(4'b0010, value);
            SHAPE_NO_DNS:    add_watched(4'b0100, value);
            SHAPE_NO_LEASE:  add_watched(4'b1000, value);
            SHAPE_TRUNCATED:
            begin
                // drop the end option and half the lease value
                add_watched(4'b0000, value);
                repeat (4) void'(msg_q.pop_back());
            end
            SHAPE_PAST_255:
            begin
                add_option(CODE_PAD, 8'd255, value);
                add_watched(4'b0000, value);
            end
            SHAPE_AT_255:
            begin
                // server id code lands on index 255 exactly, its successor is past the walk
                add_option(CODE_PAD, 8'd249, value);
                add_option(CODE_SERVER_ID, 8'd4, value);
                add_watched(4'b0001, value);
            end
            SHAPE_PAD_END:
            begin
                add_option(CODE_PAD, 8'd0, 32'd0);
                add_option(CODE_END, 8'd0, 32'd0);
                add_watched(4'b0000, value);
            end
            SHAPE_OVERLAP:
            begin
                // zero and one byte lengths put codes inside earlier value fields
                msg_q.push_back(CODE_SERVER_ID);
                msg_q.push_back(8'd0);
                msg_q.push_back(CODE_SUBNET_MASK);
                msg_q.push_back(8'd0);
                msg_q.push_back(CODE_DNS);
                msg_q.push_back(8'd0);
                msg_q.push_back(CODE_LEASE);
                msg_q.push_back(8'd1);
                repeat (4) msg_q.push_back(fill);
                add_option(CODE_END, 8'd0, 32'd0);
            end
            SHAPE_DUPLICATE:
            begin
                add_option(CODE_SERVER_ID, 8'd4, ~value);
                add_watched(4'b0000, value);
            end
            default:
            begin
                add_watched(4'b0000, value);
                while (msg_q.size() < MAX_MESSAGE_BYTES + 40)
                    msg_q.push_back(8'($urandom));
            end
        endcase
    endfunction

    function automatic void build_random_offer();
        int         r;
        int         n;
        int         t;
        int         order [SLOTS];
        logic [7:0] len;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            // short noise
            msg_q.delete();
            n = $urandom_range(1, 40);
            repeat (n) msg_q.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 1)
                msg_q[0] = OP_BOOTREPLY;
            return;
        end
        start_offer((r < 18) ? 8'($urandom) : OP_BOOTREPLY, $urandom);
        for (int s = 0; s < SLOTS; s++)
            order[s] = s;
        for (int s = SLOTS - 1; s > 0; s--)
        begin
            t = $urandom_range(0, s);
            n = order[s];
            order[s] = order[t];
            order[t] = n;
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            repeat ($urandom_range(0, 2))
                add_option(8'($urandom),
                           ($urandom_range(0, 11) == 0) ? 8'($urandom_range(100, 255))
                                                        : 8'($urandom_range(0, 10)),
                           $urandom);
            if ($urandom_range(0, 19) != 0)
            begin
                len = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 8)) : 8'd4;
                add_option(WATCHED[order[k]], len, $urandom);
                if ($urandom_range(0, 9) == 0)
                    add_option(WATCHED[order[k]], 8'd4, $urandom);
            end
        end
        if ($urandom_range(0, 1) == 1)
            add_option(CODE_END, 8'd0, 32'd0);
        repeat ($urandom_range(0, 16)) msg_q.push_back(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            n = $urandom_range(1, msg_q.size());
            while (msg_q.size() > n)
                void'(msg_q.pop_back());
        end
        else if (r < 13)
        begin
            n = $urandom_range(MAX_MESSAGE_BYTES, MAX_MESSAGE_BYTES + 80);
            while (msg_q.size() < n)
                msg_q.push_back(8'($urandom));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input logic [2:0] typed_status);
        int            gap;
        logic          done;
        offer_result_t r;
        gap = idle_gap();
        if (gap > 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid <= 1'b1;
        rx.rx_byte <= b;
        rx.last_byte <= last;
        do @(posedge clk); while (!rx.ready);
        bytes_sent++;
        parse_offer_byte(b, last, done, r);
        if (done)
        begin
            if (typed)
                r.status = typed_status;
            offer_expect_q.push_back(r);
        end
    endtask

    task automatic send_message(input logic typed, input logic [2:0] typed_status);
        for (int k = 0; k < msg_q.size(); k++)
            send_byte(msg_q[k], k == msg_q.size() - 1, typed, typed_status);
    endtask

    // called on the edge of a transfer; queue is polled away from the active edge
    task automatic wait_offers_drained();
        rx.valid <= 1'b0;
        do @(negedge clk); while (offer_expect_q.size() != 0);
        @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        offer_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (offer_expect_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, res.status);
            end
            else
            begin
                want = offer_expect_q.pop_front();
                check_field("status", 32'(want.status), 32'(res.status));
                check_field("client_ip", want.sess.client, res.client_ip);
                check_field("server_ip", want.sess.server, res.server_ip);
                check_field("subnet_mask", want.sess.mask, res.subnet_mask);
                check_field("dns_address", want.sess.dns, res.dns_address);
                check_field("lease_seconds", want.sess.lease, res.lease_seconds);
            end
        end
    end

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            res.ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            res.ready <= 1'b1;
            ready_hold <= idle_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((rx.valid && rx.ready) || (res.valid && res.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("dhcp_offer_option_parser regression: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int offers;
        rst_n = 1'b0;
        rx.valid = 1'b0;
        rx.rx_byte = '0;
        rx.last_byte = 1'b0;
        res.ready = 1'b0;
        clear_offer();
        session = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < NUM_ROWS; k++)
        begin
            quiet <= (k < 4);
            build_shape(offer_plan[k].shape, offer_plan[k].op, offer_plan[k].fill);
            send_message(offer_plan[k].typed, offer_plan[k].status);
        end
        wait_offers_drained();

        bytes_sent = 0;
        offers = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            quiet <= ($urandom_range(0, 4) == 0);
            build_random_offer();
            send_message(1'b0, ST_OK);
            offers++;
            if (offers % DRAIN_EVERY == 0)
                wait_offers_drained();
        end

        wait_offers_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && offer_expect_q.size() == 0)
            $display("dhcp_offer_option_parser regression: pass");
        else
            $display("dhcp_offer_option_parser regression: fail");
        $finish;
    end

endmodule
